// File: design/hrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types, codes and constants of the range search block.
// ----------------------------------------------------------------------------
package hrs_pkg;

	localparam int TEXT_DEPTH_DEF  = 4096;
	localparam int PATTERN_MAX_DEF = 64;

	localparam int ALPHABET = 256;
	localparam int SYM_W    = 8;
	localparam int SHIFT_W  = 7;
	localparam int LEN_W    = 7;
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 12;
	localparam int QSTART_W = 12;
	localparam int QEND_W   = 13;

	localparam logic [OP_W-1:0] OP_PAT_WR = 2'd0;
	localparam logic [OP_W-1:0] OP_TXT_WR = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_CHECK,
		ST_CMP,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               clear;
		logic               wr_en;
		logic [SYM_W-1:0]   wr_addr;
		logic [SHIFT_W-1:0] wr_data;
		logic [SYM_W-1:0]   rd_addr;
	} shift_req_t;

	// Width of a text position: holds the text depth plus one shift and the
	// 13-bit query end.
	function automatic int pos_width(input int depth);
		int w;
		begin
			w = $clog2(depth + ALPHABET) + 1;
			if (w < QEND_W + 1) begin
				w = QEND_W + 1;
			end
			return w;
		end
	endfunction

endpackage
`default_nettype wire

// File: design/hrs_byte_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_byte_ram
// Byte-wide synchronous RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hrs_byte_ram #(
	parameter int DEPTH = hrs_pkg::PATTERN_MAX_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [hrs_pkg::SYM_W-1:0] wdata,
	input  wire logic [AW-1:0]            raddr,
	output logic      [hrs_pkg::SYM_W-1:0] rdata
);

	logic [hrs_pkg::SYM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: design/hrs_shift_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_shift_table
// Bad-character shift memory with one valid flop per symbol. An entry not
// written since the last clear reports a miss; the sequencer then uses the pattern length.
// ----------------------------------------------------------------------------
module hrs_shift_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire hrs_pkg::shift_req_t         req,
	output logic      [hrs_pkg::SHIFT_W-1:0] rd_data,
	output logic                             rd_hit
);

	logic [hrs_pkg::SHIFT_W-1:0]  mem [hrs_pkg::ALPHABET];
	logic [hrs_pkg::ALPHABET-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem[req.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_hit  <= 1'b0;
		end else begin
			rd_hit <= valid_q[req.rd_addr];
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/hrs_search_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_search_ctrl
// Query sequencer: builds the shift table from the pattern memory, then
// slides the window over the text memory comparing right to left.
// ----------------------------------------------------------------------------
module hrs_search_ctrl #(
	parameter int TEXT_DEPTH  = hrs_pkg::TEXT_DEPTH_DEF,
	parameter int PATTERN_MAX = hrs_pkg::PATTERN_MAX_DEF,
	parameter int TW          = $clog2(TEXT_DEPTH),
	parameter int PAW         = $clog2(PATTERN_MAX)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [hrs_pkg::QSTART_W-1:0] query_start,
	input  wire logic [hrs_pkg::QEND_W-1:0]   query_end,
	input  wire logic [hrs_pkg::LEN_W-1:0]    pattern_length,
	output logic      [PAW-1:0]               pat_raddr,
	input  wire logic [hrs_pkg::SYM_W-1:0]    pat_rdata,
	output logic      [TW-1:0]                txt_raddr,
	input  wire logic [hrs_pkg::SYM_W-1:0]    txt_rdata,
	output hrs_pkg::shift_req_t               shift_req,
	input  wire logic [hrs_pkg::SHIFT_W-1:0]  shift_rdata,
	input  wire logic                         shift_hit,
	output logic                              busy,
	output logic                              done,
	output logic                              done_found,
	input  wire logic                         done_take
);

	localparam int PW = hrs_pkg::pos_width(TEXT_DEPTH);

	hrs_pkg::state_t state_q, state_d;

	logic [PW-1:0]                  pos_q;
	logic [PW-1:0]                  end_q;
	logic [hrs_pkg::LEN_W-1:0]      j_q;
	logic [hrs_pkg::LEN_W-1:0]      k_q;
	logic [hrs_pkg::SYM_W-1:0]      last_q;
	logic                           found_q;
	logic                           bld_v_s1;
	logic [hrs_pkg::SHIFT_W-1:0]    bld_w_s1;

	logic [hrs_pkg::LEN_W-1:0]      m;
	logic [PW-1:0]                  end_ext;
	logic [PW-1:0]                  end_clamped;
	logic                           bld_issue;
	logic                           win_ok;
	logic                           first_cmp;
	logic                           hit;
	logic [hrs_pkg::LEN_W-1:0]      rd_j;
	logic [hrs_pkg::SHIFT_W-1:0]    shift_amt;

	// Effective pattern length: zero counts as one, saturate at the store size.
	always_comb begin
		if (pattern_length == '0) begin
			m = hrs_pkg::LEN_W'(1);
		end else if (9'(pattern_length) > 9'(PATTERN_MAX)) begin
			m = hrs_pkg::LEN_W'(PATTERN_MAX);
		end else begin
			m = pattern_length;
		end
	end

	assign end_ext     = PW'(query_end);
	assign end_clamped = (end_ext > PW'(TEXT_DEPTH)) ? PW'(TEXT_DEPTH) : end_ext;
	assign bld_issue   = (8'(k_q) + 8'd1) < 8'(m);
	assign win_ok      = (pos_q + PW'(m)) <= end_q;
	assign first_cmp   = (j_q == (m - hrs_pkg::LEN_W'(1)));
	assign hit         = (pat_rdata == txt_rdata);
	assign rd_j        = (state_q == hrs_pkg::ST_CHECK) ? (m - hrs_pkg::LEN_W'(1))
	                                                    : (j_q - hrs_pkg::LEN_W'(1));
	assign shift_amt   = shift_hit ? shift_rdata : m;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hrs_pkg::ST_IDLE: begin
				if (start) begin
					state_d = hrs_pkg::ST_BUILD;
				end
			end
			hrs_pkg::ST_BUILD: begin
				if (!bld_issue && !bld_v_s1) begin
					state_d = hrs_pkg::ST_CHECK;
				end
			end
			hrs_pkg::ST_CHECK: begin
				state_d = win_ok ? hrs_pkg::ST_CMP : hrs_pkg::ST_DONE;
			end
			hrs_pkg::ST_CMP: begin
				if (!hit) begin
					state_d = hrs_pkg::ST_SHIFT;
				end else if (j_q == '0) begin
					state_d = hrs_pkg::ST_DONE;
				end
			end
			hrs_pkg::ST_SHIFT: begin
				state_d = hrs_pkg::ST_CHECK;
			end
			hrs_pkg::ST_DONE: begin
				if (done_take) begin
					state_d = hrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		shift_req         = '0;
		shift_req.wr_en   = bld_v_s1;
		shift_req.wr_addr = pat_rdata;
		shift_req.wr_data = bld_w_s1;
		shift_req.rd_addr = first_cmp ? txt_rdata : last_q;
		pat_raddr         = PAW'(rd_j);
		txt_raddr         = TW'(pos_q + PW'(rd_j));
		busy              = 1'b1;
		done              = 1'b0;
		done_found        = found_q;
		unique case (state_q)
			hrs_pkg::ST_IDLE: begin
				busy            = 1'b0;
				shift_req.clear = start;
			end
			hrs_pkg::ST_BUILD: begin
				pat_raddr = PAW'(k_q);
			end
			hrs_pkg::ST_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hrs_pkg::ST_IDLE;
			bld_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			bld_v_s1 <= (state_q == hrs_pkg::ST_BUILD) && bld_issue;
		end
	end

	always_ff @(posedge clk) begin
		bld_w_s1 <= m - hrs_pkg::LEN_W'(1) - k_q;
		unique case (state_q)
			hrs_pkg::ST_IDLE: begin
				pos_q <= PW'(query_start);
				end_q <= end_clamped;
				k_q   <= '0;
			end
			hrs_pkg::ST_BUILD: begin
				if (bld_issue) begin
					k_q <= k_q + hrs_pkg::LEN_W'(1);
				end
			end
			hrs_pkg::ST_CHECK: begin
				j_q <= rd_j;
				if (!win_ok) begin
					found_q <= 1'b0;
				end
			end
			hrs_pkg::ST_CMP: begin
				// keep the window's last text byte for the shift lookup
				if (first_cmp) begin
					last_q <= txt_rdata;
				end
				if (hit) begin
					j_q <= rd_j;
					if (j_q == '0) begin
						found_q <= 1'b1;
					end
				end
			end
			hrs_pkg::ST_SHIFT: begin
				pos_q <= pos_q + PW'(shift_amt);
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/horspool_range_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// horspool_range_search_core
// Pattern search over a window of a stored text using bad-character shifts.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    opcode, address, data_byte,
//                                                  query_start, query_end
//  result    out        result_valid / result_stall found
//  config    in         cfg_wr_en                  cfg_wr_data (pattern length)
//
//  A write item does not raise item_stall. A query first builds the shift
//  table, reading each pattern byte but the last and writing its shift
//  from a registered stage; then each window alignment passes a check
//  state, a compare state that walks the bytes right to left and a shift
//  state; a done state hands the result off. No clearing pass after reset:
//  the shift table's valid flops clear as each query is accepted. item_stall
//  is high while a query runs; a result waits in the output register.
// ----------------------------------------------------------------------------
module horspool_range_search_core #(
	parameter int TEXT_DEPTH  = hrs_pkg::TEXT_DEPTH_DEF,
	parameter int PATTERN_MAX = hrs_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic [hrs_pkg::OP_W-1:0]     opcode,
	input  wire logic [hrs_pkg::ADDR_W-1:0]   address,
	input  wire logic [hrs_pkg::SYM_W-1:0]    data_byte,
	input  wire logic [hrs_pkg::QSTART_W-1:0] query_start,
	input  wire logic [hrs_pkg::QEND_W-1:0]   query_end,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic                              found,
	input  wire logic                         cfg_wr_en,
	input  wire logic [hrs_pkg::LEN_W-1:0]    cfg_wr_data
);

	localparam int TW  = $clog2(TEXT_DEPTH);
	localparam int PAW = $clog2(PATTERN_MAX);
	localparam int PW  = hrs_pkg::pos_width(TEXT_DEPTH);

	logic [hrs_pkg::LEN_W-1:0] pattern_length_q;
	logic                      item_acc;
	logic                      query_go;
	logic                      pat_we;
	logic                      txt_we;
	logic [PAW-1:0]            pat_raddr;
	logic [TW-1:0]             txt_raddr;
	logic [hrs_pkg::SYM_W-1:0] pat_rdata;
	logic [hrs_pkg::SYM_W-1:0] txt_rdata;
	hrs_pkg::shift_req_t       shift_req;
	logic [hrs_pkg::SHIFT_W-1:0] shift_rdata;
	logic                      shift_hit;
	logic                      busy;
	logic                      done;
	logic                      done_found;
	logic                      out_free;

	assign item_stall = busy;
	assign item_acc   = item_valid && !item_stall;
	assign query_go   = item_acc && (opcode == hrs_pkg::OP_QUERY);
	// drop writes beyond the stores
	assign pat_we     = item_acc && (opcode == hrs_pkg::OP_PAT_WR)
	                    && (13'(address) < 13'(PATTERN_MAX));
	assign txt_we     = item_acc && (opcode == hrs_pkg::OP_TXT_WR)
	                    && (PW'(address) < PW'(TEXT_DEPTH));
	assign out_free   = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= hrs_pkg::LEN_W'(1);
		end else if (cfg_wr_en) begin
			pattern_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && done) begin
			found <= done_found;
		end
	end

	hrs_byte_ram #(
		.DEPTH (PATTERN_MAX),
		.AW    (PAW)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (PAW'(address)),
		.wdata (data_byte),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	hrs_byte_ram #(
		.DEPTH (TEXT_DEPTH),
		.AW    (TW)
	) u_txt_ram (
		.clk   (clk),
		.we    (txt_we),
		.waddr (TW'(address)),
		.wdata (data_byte),
		.raddr (txt_raddr),
		.rdata (txt_rdata)
	);

	hrs_shift_table u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (shift_req),
		.rd_data (shift_rdata),
		.rd_hit  (shift_hit)
	);

	hrs_search_ctrl #(
		.TEXT_DEPTH  (TEXT_DEPTH),
		.PATTERN_MAX (PATTERN_MAX),
		.TW          (TW),
		.PAW         (PAW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (query_go),
		.query_start    (query_start),
		.query_end      (query_end),
		.pattern_length (pattern_length_q),
		.pat_raddr      (pat_raddr),
		.pat_rdata      (pat_rdata),
		.txt_raddr      (txt_raddr),
		.txt_rdata      (txt_rdata),
		.shift_req      (shift_req),
		.shift_rdata    (shift_rdata),
		.shift_hit      (shift_hit),
		.busy           (busy),
		.done           (done),
		.done_found     (done_found),
		.done_take      (out_free)
	);

	a_query_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		query_go |=> item_stall)
		else $error("query accepted but input not stalled");

	a_busy_only_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(query_go))
		else $error("sequencer left idle without a query");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_free) |=> (result_valid && !busy))
		else $error("finished query not moved to output register");

	a_shift_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		shift_req.clear |-> (!busy && !shift_req.wr_en))
		else $error("shift table cleared during a query");

endmodule
`default_nettype wire

// File: sim/horspool_range_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horspool_range_search_core_tb
// Self-checking bench for the range search core. A short table of directed
// items comes first, then phases of random writes and queries, one pattern
// length per phase. Typed table rows carry their expected result; every other
// query result is compared with an in-bench Horspool search over shadow copies of the text and pattern stores.
// ----------------------------------------------------------------------------
module horspool_range_search_core_tb;

	localparam logic [hrs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 210;
	localparam int N_ROWS = 21;

	typedef struct packed {
		logic [hrs_pkg::OP_W-1:0]     op;
		logic [hrs_pkg::ADDR_W-1:0]   addr;
		logic [hrs_pkg::SYM_W-1:0]    data;
		logic [hrs_pkg::QSTART_W-1:0] qs;
		logic [hrs_pkg::QEND_W-1:0]   qe;
		logic                         typed;
		logic                         want;
	} table_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_stall;
	logic [hrs_pkg::OP_W-1:0]     opcode;
	logic [hrs_pkg::ADDR_W-1:0]   address;
	logic [hrs_pkg::SYM_W-1:0]    data_byte;
	logic [hrs_pkg::QSTART_W-1:0] query_start;
	logic [hrs_pkg::QEND_W-1:0]   query_end;
	logic                         result_valid;
	logic                         result_stall;
	logic                         found;
	logic                         cfg_wr_en;
	logic [hrs_pkg::LEN_W-1:0]    cfg_wr_data;

	// shadow state of the block
	logic [hrs_pkg::SYM_W-1:0] shadow_text [hrs_pkg::TEXT_DEPTH_DEF];
	logic [hrs_pkg::SYM_W-1:0] shadow_pat [hrs_pkg::PATTERN_MAX_DEF];
	logic [hrs_pkg::LEN_W-1:0] shadow_len;
	bit                        txt_ok [hrs_pkg::TEXT_DEPTH_DEF];
	bit                        pat_ok [hrs_pkg::PATTERN_MAX_DEF];

	bit  pending_found [$];
	bit  want_found;
	int  fail_count = 0;
	int  useful_items = 0;
	int  quiet_cycles = 0;
	int  stall_cnt = 0;
	bit  idle_on = 1'b1;
	bit  table_want_en = 1'b0;
	bit  table_want = 1'b0;
	bit  full_alpha;
	int  alpha_base;
	int  alpha_n;

	table_row_t seed_rows [N_ROWS] = '{
		'{hrs_pkg::OP_PAT_WR, 12'd0,    8'hFF, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_PAT_WR, 12'd64,   8'h00, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_PAT_WR, 12'd4095, 8'h00, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_TXT_WR, 12'd0,    8'h00, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_TXT_WR, 12'd1,    8'hFF, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_TXT_WR, 12'd4094, 8'h00, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_TXT_WR, 12'd4095, 8'hFF, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd0,    13'd2,    1'b1, 1'b1},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd0,    13'd1,    1'b1, 1'b0},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd0,    13'd0,    1'b1, 1'b0},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd4095, 13'd8191, 1'b1, 1'b1},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd4094, 13'd4096, 1'b1, 1'b1},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd4095, 13'd4095, 1'b1, 1'b0},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd4095, 13'd0,    1'b1, 1'b0},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd4094, 13'd4095, 1'b1, 1'b0},
		'{OP_UNUSED,          12'd4095, 8'hFF, 12'd4095, 13'd8191, 1'b0, 1'b0},
		'{hrs_pkg::OP_TXT_WR, 12'd2,    8'hA5, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_PAT_WR, 12'd0,    8'hA5, 12'd0,    13'd0,    1'b0, 1'b0},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd0,    13'd3,    1'b1, 1'b1},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd1,    13'd2,    1'b1, 1'b0},
		'{hrs_pkg::OP_QUERY,  12'd0,    8'h00, 12'd1,    13'd3,    1'b0, 1'b0}
	};

	horspool_range_search_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.address      (address),
		.data_byte    (data_byte),
		.query_start  (query_start),
		.query_end    (query_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #1 clk = ~clk;

	function automatic logic [hrs_pkg::ADDR_W-1:0] rnd_addr();
		return hrs_pkg::ADDR_W'($urandom);
	endfunction

	function automatic logic [hrs_pkg::SYM_W-1:0] rnd_byte();
		return hrs_pkg::SYM_W'($urandom);
	endfunction

	function automatic logic [hrs_pkg::QSTART_W-1:0] rnd_qs();
		return hrs_pkg::QSTART_W'($urandom);
	endfunction

	function automatic logic [hrs_pkg::QEND_W-1:0] rnd_qe();
		return hrs_pkg::QEND_W'($urandom);
	endfunction

	function automatic int eff_len();
		int m;
		m = int'(shadow_len);
		if (m < 1) begin
			m = 1;
		end
		if (m > hrs_pkg::PATTERN_MAX_DEF) begin
			m = hrs_pkg::PATTERN_MAX_DEF;
		end
		return m;
	endfunction

	// Horspool search over the shadow stores, end clamped to the text depth
	function automatic bit calc_found(input logic [hrs_pkg::QSTART_W-1:0] qs,
			input logic [hrs_pkg::QEND_W-1:0] qe);
		int m;
		int pos;
		int lim;
		int j;
		int k;
		bit hit;
		int shift_of [hrs_pkg::ALPHABET];
		m = eff_len();
		lim = (int'(qe) > hrs_pkg::TEXT_DEPTH_DEF) ? hrs_pkg::TEXT_DEPTH_DEF : int'(qe);
		for (k = 0; k < hrs_pkg::ALPHABET; k++) begin
			shift_of[k] = m;
		end
		for (k = 0; k + 1 < m; k++) begin
			shift_of[shadow_pat[k]] = m - 1 - k;
		end
		pos = int'(qs);
		while (pos <= lim && lim - pos >= m) begin
			hit = 1'b1;
			for (j = m - 1; j >= 0 && hit; j--) begin
				if (shadow_pat[j] != shadow_text[pos + j]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				return 1'b1;
			end
			pos = pos + shift_of[shadow_text[pos + m - 1]];
		end
		return 1'b0;
	endfunction

	function automatic logic [hrs_pkg::SYM_W-1:0] pick_byte();
		if (full_alpha) begin
			return hrs_pkg::SYM_W'($urandom_range(0, 255));
		end
		return hrs_pkg::SYM_W'(alpha_base + int'($urandom_range(0, alpha_n - 1)));
	endfunction

	task automatic note_fail(input string what, input bit want, input logic got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s: expected found=%0d, got %b", $time, what, want, got);
		end
	endtask

	task automatic send_item(input logic [hrs_pkg::OP_W-1:0] op,
			input logic [hrs_pkg::ADDR_W-1:0] addr,
			input logic [hrs_pkg::SYM_W-1:0] data,
			input logic [hrs_pkg::QSTART_W-1:0] qs,
			input logic [hrs_pkg::QEND_W-1:0] qe);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_valid = 1'b0;
			opcode = hrs_pkg::OP_W'($urandom);
			address = rnd_addr();
			data_byte = rnd_byte();
			query_start = rnd_qs();
			query_end = rnd_qe();
			gap = int'($urandom_range(1, 16));
			repeat (gap) @(negedge clk);
		end
		item_valid = 1'b1;
		opcode = op;
		address = addr;
		data_byte = data;
		query_start = qs;
		query_end = qe;
		@(posedge clk);
		while (item_stall !== 1'b0) @(posedge clk);
		case (op)
			hrs_pkg::OP_QUERY: begin
				pending_found.push_back(table_want_en ? table_want : calc_found(qs, qe));
			end
			hrs_pkg::OP_PAT_WR: begin
				if (addr < hrs_pkg::PATTERN_MAX_DEF) begin
					shadow_pat[addr] = data;
					pat_ok[addr] = 1'b1;
				end
			end
			hrs_pkg::OP_TXT_WR: begin
				shadow_text[addr] = data;
				txt_ok[addr] = 1'b1;
			end
			default: ;
		endcase
		if (op != OP_UNUSED
				&& !(op == hrs_pkg::OP_PAT_WR && addr >= hrs_pkg::PATTERN_MAX_DEF)) begin
			useful_items++;
		end
	endtask

	// fill every unwritten text byte that a query over [s, e) would read
	task automatic ensure_text(input int s, input int e, input int m);
		int lim;
		int i;
		lim = (e > hrs_pkg::TEXT_DEPTH_DEF) ? hrs_pkg::TEXT_DEPTH_DEF : e;
		if (s + m <= lim) begin
			for (i = s; i < lim; i++) begin
				if (!txt_ok[i]) begin
					send_item(hrs_pkg::OP_TXT_WR, hrs_pkg::ADDR_W'(i), pick_byte(),
						rnd_qs(), rnd_qe());
				end
			end
		end
	endtask

	task automatic ensure_pattern(input int m);
		int k;
		for (k = 0; k < m; k++) begin
			if (!pat_ok[k]) begin
				send_item(hrs_pkg::OP_PAT_WR, hrs_pkg::ADDR_W'(k), pick_byte(),
					rnd_qs(), rnd_qe());
			end
		end
	endtask

	// drain all queries, let trailing writes retire, then load the length
	task automatic write_len(input logic [hrs_pkg::LEN_W-1:0] v);
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_found.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_wr_data = hrs_pkg::LEN_W'($urandom);
		shadow_len = v;
	endtask

	always @(negedge clk) begin
		if (!idle_on) begin
			result_stall = 1'b0;
		end else if (stall_cnt != 0) begin
			stall_cnt = stall_cnt - 1;
		end else if (result_stall) begin
			result_stall = 1'b0;
			stall_cnt = ($urandom_range(0, 3) == 0) ? 200 : int'($urandom_range(0, 40));
		end else begin
			result_stall = 1'b1;
			stall_cnt = int'($urandom_range(0, 15));
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (pending_found.size() == 0) begin
				note_fail("result with no query pending", 1'b0, found);
			end else begin
				want_found = pending_found.pop_front();
				if (found !== want_found) begin
					note_fail("found mismatch", want_found, found);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("horspool_range_search_core_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int ph;
		int r;
		int pick;
		int m;
		int s;
		int e;
		int pos;
		int k;
		int ck;
		int zone;
		int budget;
		bit corrupt;
		logic [hrs_pkg::SYM_W-1:0] b;
		logic [hrs_pkg::LEN_W-1:0] len_plan [PHASES];

		len_plan = '{7'd64, 7'd0, 7'd2, 7'd127, 7'd5, 7'd65, 7'd1, 7'd0};
		len_plan[PHASES - 1] = hrs_pkg::LEN_W'($urandom_range(3, 63));
		arst_n = 1'b0;
		item_valid = 1'b0;
		opcode = '0;
		address = '0;
		data_byte = '0;
		query_start = '0;
		query_end = '0;
		result_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		shadow_len = 7'd1;
		full_alpha = 1'b1;
		alpha_base = 0;
		alpha_n = 2;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < N_ROWS; r++) begin
			table_want_en = seed_rows[r].typed;
			table_want = seed_rows[r].want;
			send_item(seed_rows[r].op, seed_rows[r].addr, seed_rows[r].data,
				seed_rows[r].qs, seed_rows[r].qe);
			table_want_en = 1'b0;
		end

		for (ph = 0; ph < PHASES; ph++) begin
			write_len(len_plan[ph]);
			idle_on = (ph != PHASES - 1);
			full_alpha = $urandom_range(0, 1);
			alpha_n = int'($urandom_range(2, 4));
			alpha_base = int'($urandom_range(0, 252));
			if (ph == 0) begin
				zone = 0;
			end else if (ph % 3 == 2) begin
				zone = hrs_pkg::TEXT_DEPTH_DEF - 160;
			end else begin
				zone = int'($urandom_range(0, hrs_pkg::TEXT_DEPTH_DEF - 160));
			end
			budget = useful_items + PHASE_ITEMS;
			while (useful_items < budget) begin
				m = eff_len();
				ensure_pattern(m);
				pick = int'($urandom_range(0, 99));
				if (pick < 40) begin
					// plant the pattern in the text, sometimes with one bad byte
					pos = zone + int'($urandom_range(0, 64));
					if (pos + m > hrs_pkg::TEXT_DEPTH_DEF) begin
						pos = hrs_pkg::TEXT_DEPTH_DEF - m;
					end
					s = pos - int'($urandom_range(0, 8));
					if (s < 0) begin
						s = 0;
					end
					e = pos + m + int'($urandom_range(0, 8));
					if ($urandom_range(0, 4) == 0) begin
						e = pos + m - 1;
					end
					if (e >= hrs_pkg::TEXT_DEPTH_DEF && $urandom_range(0, 1) == 1) begin
						e = int'($urandom_range(hrs_pkg::TEXT_DEPTH_DEF, 8191));
					end
					ensure_text(s, e, m);
					corrupt = ($urandom_range(0, 3) == 0);
					ck = int'($urandom_range(0, m - 1));
					for (k = 0; k < m; k++) begin
						b = shadow_pat[k];
						if (corrupt && k == ck) begin
							b = b ^ (8'h01 << $urandom_range(0, 7));
						end
						send_item(hrs_pkg::OP_TXT_WR, hrs_pkg::ADDR_W'(pos + k), b,
							rnd_qs(), rnd_qe());
					end
					send_item(hrs_pkg::OP_QUERY, rnd_addr(), rnd_byte(),
						hrs_pkg::QSTART_W'(s), hrs_pkg::QEND_W'(e));
				end else if (pick < 65) begin
					s = zone + int'($urandom_range(0, 64));
					e = s + int'($urandom_range(0, m + 32));
					if (e >= hrs_pkg::TEXT_DEPTH_DEF && $urandom_range(0, 1) == 1) begin
						e = int'($urandom_range(hrs_pkg::TEXT_DEPTH_DEF, 8191));
					end
					ensure_text(s, e, m);
					send_item(hrs_pkg::OP_QUERY, rnd_addr(), rnd_byte(),
						hrs_pkg::QSTART_W'(s), hrs_pkg::QEND_W'(e));
				end else if (pick < 78) begin
					// window too short, empty or reversed: reads no text
					s = int'($urandom_range(0, hrs_pkg::TEXT_DEPTH_DEF - 1));
					if ($urandom_range(0, 3) == 0) begin
						e = int'($urandom_range(0, s));
					end else begin
						e = s + int'($urandom_range(0, m - 1));
						if (e >= hrs_pkg::TEXT_DEPTH_DEF && $urandom_range(0, 1) == 1) begin
							e = int'($urandom_range(hrs_pkg::TEXT_DEPTH_DEF, 8191));
						end
					end
					send_item(hrs_pkg::OP_QUERY, rnd_addr(), rnd_byte(),
						hrs_pkg::QSTART_W'(s), hrs_pkg::QEND_W'(e));
				end else if (pick < 88) begin
					send_item(hrs_pkg::OP_TXT_WR,
						hrs_pkg::ADDR_W'($urandom_range(0, hrs_pkg::TEXT_DEPTH_DEF - 1)),
						rnd_byte(), rnd_qs(), rnd_qe());
				end else if (pick < 96) begin
					if ($urandom_range(0, 4) < 3) begin
						send_item(hrs_pkg::OP_PAT_WR,
							hrs_pkg::ADDR_W'($urandom_range(0, m - 1)), pick_byte(),
							rnd_qs(), rnd_qe());
					end else begin
						send_item(hrs_pkg::OP_PAT_WR,
							hrs_pkg::ADDR_W'($urandom_range(hrs_pkg::PATTERN_MAX_DEF, 4095)),
							rnd_byte(), rnd_qs(), rnd_qe());
					end
				end else begin
					send_item(OP_UNUSED, rnd_addr(), rnd_byte(), rnd_qs(), rnd_qe());
				end
			end
		end

		@(negedge clk);
		item_valid = 1'b0;
		while (pending_found.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("horspool_range_search_core_tb: clean");
		end else begin
			$display("horspool_range_search_core_tb: errors");
		end
		$finish;
	end

endmodule
